/* rtl/assert_macros.svh */
// Assertion macros shared by the sequencer modules.
// Expects signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, disabled while reset is high.
`define IMU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define IMU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* rtl/imu_seq_pkg.sv */
// Shared types and constants for the sensor sample sequencer.
// No dependencies; imported by every sequencer module.
package imu_seq_pkg;

   localparam int FIELD_COUNT = 12;

   // Transaction kinds on the request channel
   localparam logic [1:0] KIND_COMPLETE = 2'd0;
   localparam logic [1:0] KIND_START    = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;

   // Sequence steps (field indexes)
   localparam logic [3:0] STEP_ROLL    = 4'd0;
   localparam logic [3:0] STEP_HEADING = 4'd2;
   localparam logic [3:0] STEP_DROLL   = 4'd3;
   localparam logic [3:0] STEP_ACCX    = 4'd6;
   localparam logic [3:0] STEP_ACCY    = 4'd7;
   localparam logic [3:0] STEP_STATUS  = 4'd9;
   localparam logic [3:0] STEP_ERROR   = 4'd10;
   localparam logic [3:0] STEP_CALIB   = 4'd11;
   localparam logic [3:0] STEP_HALT    = 4'(FIELD_COUNT);

   typedef struct packed {
      logic [1:0]         kind;
      logic               transfer_ok;
      logic signed [15:0] read_data;
      logic [3:0]         field_select;
   } req_payload_type;

   typedef struct packed {
      logic               request_valid;
      logic [3:0]         request_target;
      logic signed [15:0] field_value;
      logic               sampling_fault;
      logic               pass_done;
   } rsp_payload_type;

   // Write command from the sequencer control to the sample buffers
   typedef struct packed {
      logic        write_enable;
      logic        bank;
      logic [3:0]  index;
      logic [15:0] data;
      logic        clear_error;
   } buf_write_type;

endpackage

/* rtl/imu_seq_buffers.sv */
// Double-buffered sample store: two banks of FIELD_COUNT 16-bit fields.
// Depends on imu_seq_pkg for the field count, step codes and write command.
module imu_seq_buffers (
   input  logic                       clock,
   input  logic                       reset,
   input  imu_seq_pkg::buf_write_type wr,
   input  logic                       rd_bank,
   input  logic [3:0]                 rd_select,
   output logic [15:0]                rd_value
);
   import imu_seq_pkg::*;

   logic [15:0] sample_buffers_ff [2][FIELD_COUNT];

   // Clear both banks at reset, then take one field write per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < 2; b++) begin
            for (int f = 0; f < FIELD_COUNT; f++) begin
               sample_buffers_ff[b][f] <= '0;
            end
         end
      end else if (wr.write_enable) begin
         sample_buffers_ff[wr.bank][wr.index] <= wr.data;
         if (wr.clear_error) begin
            sample_buffers_ff[wr.bank][STEP_ERROR] <= '0;
         end
      end
   end

   // Read one field; selects past the last field read as zero
   always_comb begin
      rd_value = '0;
      if (rd_select < 4'(FIELD_COUNT)) begin
         rd_value = sample_buffers_ff[rd_bank][rd_select];
      end
   end

endmodule

/* rtl/imu_seq_control.sv */
// Sequencer control: step and bank state, system error code register and
// per-transaction decode. Depends on imu_seq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module imu_seq_control (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  imu_seq_pkg::req_payload_type item,
   input  logic                         csr_write_enable,
   input  logic [7:0]                   csr_write_data,
   input  logic [15:0]                  rd_value,
   output logic                         rd_bank,
   output logic [3:0]                   rd_select,
   output imu_seq_pkg::buf_write_type   wr,
   output imu_seq_pkg::rsp_payload_type result
);
   import imu_seq_pkg::*;

   logic [3:0]  step_ff, step_in;
   logic        fill_ff, fill_in;
   logic [7:0]  sys_error_code_ff;
   logic [15:0] fixed_value;
   logic        pass_end;

   // Read the published bank at the requested field
   assign rd_bank   = ~fill_ff;
   assign rd_select = item.field_select;

   // Apply the per-field fix to the returned data
   always_comb begin
      fixed_value = item.read_data;
      case (step_ff) inside
         STEP_ROLL, STEP_DROLL, STEP_ACCX, STEP_ACCY: begin
            fixed_value = 16'(~item.read_data + 16'd1);
         end
         STEP_HEADING: begin
            if (item.read_data > 16'sd180) begin
               fixed_value = 16'(item.read_data - 16'sd360);
            end
         end
         STEP_STATUS, STEP_ERROR, STEP_CALIB: begin
            fixed_value = {8'd0, item.read_data[7:0]};
         end
         default: begin
            fixed_value = item.read_data;
         end
      endcase
   end

   // Decode the transaction: next state, buffer write and result
   always_comb begin
      step_in  = step_ff;
      fill_in  = fill_ff;
      pass_end = 1'b0;
      wr       = '{write_enable: 1'b0, bank: fill_ff, index: step_ff,
                   data: fixed_value, clear_error: 1'b0};
      result   = '0;
      unique case (item.kind)
         KIND_START: begin
            step_in = STEP_ROLL;
            fill_in = 1'b0;
            result.request_valid  = 1'b1;
            result.request_target = STEP_ROLL;
         end
         KIND_READ: begin
            result.field_value = rd_value;
         end
         KIND_COMPLETE: begin
            if (step_ff < STEP_HALT) begin
               if (!item.transfer_ok) begin
                  step_in = STEP_HALT;
               end else begin
                  wr.write_enable = 1'b1;
                  step_in = 4'(step_ff + 4'd1);
                  if (step_ff == STEP_STATUS &&
                      fixed_value[7:0] != sys_error_code_ff) begin
                     wr.clear_error = 1'b1;
                     step_in = STEP_CALIB;
                  end
                  if (step_ff == STEP_CALIB) begin
                     fill_in  = ~fill_ff;
                     step_in  = STEP_ROLL;
                     pass_end = 1'b1;
                  end
                  result.request_valid  = 1'b1;
                  result.request_target = step_in;
               end
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
      result.pass_done      = pass_end;
      result.sampling_fault = (step_in == STEP_HALT);
   end

   // Hold state; advance only when the transaction is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_HALT;
         fill_ff <= 1'b0;
      end else if (enable) begin
         step_ff <= step_in;
         fill_ff <= fill_in;
      end
   end

   // System error code register
   always_ff @(posedge clock) begin
      if (reset) begin
         sys_error_code_ff <= 8'd1;
      end else if (csr_write_enable) begin
         sys_error_code_ff <= csr_write_data;
      end
   end

   `IMU_ASSERT(a_step_range, step_ff <= STEP_HALT, "sequence step out of range")
   `IMU_ASSERT(a_bank_flip,
      (enable && pass_end) |=> (fill_ff != $past(fill_ff)), "bank did not flip")

endmodule

/* rtl/imu_sample_sequencer_core.sv */
// Top level of the sensor sample sequencer: input register, control,
// sample buffers and result register. Depends on imu_seq_pkg and the submodules.
//
//   channel   ports                          direction  payload
//   request   req_valid/req_stall/req_data   in         req_payload_type
//   result    rsp_valid/rsp_stall/rsp_data   out        rsp_payload_type
//   csr       csr_write_enable/_data         in         system error code
//
// One transaction per cycle unless rsp_stall holds the result register.
// The work is one pass through the control decode between the input register
// and the result register.
// Reset is synchronous; it clears both sample banks and halts the sequencer.
// A stalled result holds both stages; the input register still fills when empty.
`include "assert_macros.svh"
module imu_sample_sequencer_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  imu_seq_pkg::req_payload_type req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output imu_seq_pkg::rsp_payload_type rsp_data,
   input  logic                         csr_write_enable,
   input  logic [7:0]                   csr_write_data
);
   import imu_seq_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type result;
   buf_write_type   wr;
   logic            rd_bank;
   logic [3:0]      rd_select;
   logic [15:0]     rd_value;
   logic            advance;
   logic            accept;

   // Move the held transaction on unless the result register is blocked
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   imu_seq_control u_control (
      .clock            (clock),
      .reset            (reset),
      .enable           (advance),
      .item             (in_data_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rd_value         (rd_value),
      .rd_bank          (rd_bank),
      .rd_select        (rd_select),
      .wr               (wr),
      .result           (result)
   );

   buf_write_type wr_gated;
   always_comb begin
      wr_gated = wr;
      wr_gated.write_enable = wr.write_enable && advance;
   end

   imu_seq_buffers u_buffers (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr_gated),
      .rd_bank   (rd_bank),
      .rd_select (rd_select),
      .rd_value  (rd_value)
   );

   // Hold handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `IMU_ASSERT(a_pass_restart,
      (rsp_valid_ff && rsp_data_ff.pass_done) |->
         (rsp_data_ff.request_valid && rsp_data_ff.request_target == STEP_ROLL),
      "pass end without roll request")
   `IMU_ASSERT(a_fault_quiet,
      (rsp_valid_ff && rsp_data_ff.sampling_fault) |-> !rsp_data_ff.request_valid,
      "request issued while halted")
   `IMU_ASSERT_ALWAYS(a_reset_empty,
      reset |=> (!rsp_valid_ff && !in_valid_ff), "pipeline not empty after reset")

endmodule
